/* hw/rtl/qvr_pkg.sv */
// shared widths for the quaternion point rotation pipeline
package qvr_pkg;

    // default field widths
    localparam int QVR_QUAT_WIDTH  = 16;
    localparam int QVR_COORD_WIDTH = 24;

    // the accumulator is kept modulo 2^64 at most
    localparam int QVR_ACC_MAX_WIDTH = 64;

endpackage

/* hw/rtl/qvr_round_sat.sv */
// round, rescale and saturate one accumulated coordinate
module qvr_round_sat #(
    parameter int QUAT_WIDTH  = qvr_pkg::QVR_QUAT_WIDTH,
    parameter int COORD_WIDTH = qvr_pkg::QVR_COORD_WIDTH,
    parameter int ACC_WIDTH   = 60
) (
    input  logic signed [ACC_WIDTH-1:0]   acc,
    output logic signed [COORD_WIDTH-1:0] coord,
    output logic                          clipped
);
    import qvr_pkg::*;

    localparam int SH = 2 * (QUAT_WIDTH - 1);
    localparam int RW = ACC_WIDTH - SH;
    localparam int EW = (RW > COORD_WIDTH) ? RW : COORD_WIDTH;

    localparam logic [ACC_WIDTH-1:0] HALF = ACC_WIDTH'(1) << (SH - 1);
    localparam logic signed [EW-1:0] HI =
        signed'({{(EW - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}});
    localparam logic signed [EW-1:0] LO = ~HI;

    logic [ACC_WIDTH-1:0]  rounded;
    logic signed [RW-1:0]  shifted;
    logic signed [EW-1:0]  wide;

    // add half, then drop the fraction bits
    always_comb
    begin
        rounded = acc + HALF;
        shifted = signed'(rounded[ACC_WIDTH-1:SH]);
        wide    = EW'(shifted);
    end

    // clip to the coordinate range
    always_comb
    begin
        if (wide > HI)
        begin
            coord   = HI[COORD_WIDTH-1:0];
            clipped = 1'b1;
        end
        else if (wide < LO)
        begin
            coord   = LO[COORD_WIDTH-1:0];
            clipped = 1'b1;
        end
        else
        begin
            coord   = wide[COORD_WIDTH-1:0];
            clipped = 1'b0;
        end
    end

endmodule

/* hw/rtl/quaternion_vector_rotation.sv */
// Quaternion rotation of a 3D point, q * (0,p) * conj(q), five-stage pipeline.
// Throughput: one beat per cycle while out_stall is low; each stage holds one beat and bubbles collapse.
// Stages: point products, first Hamilton sums, quaternion products,
//   second Hamilton sums, round and saturate into the output register.
// Reset: rst_n asynchronous active low clears all stage valid bits.
module quaternion_vector_rotation #(
    parameter int QUAT_WIDTH  = qvr_pkg::QVR_QUAT_WIDTH,
    parameter int COORD_WIDTH = qvr_pkg::QVR_COORD_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [QUAT_WIDTH-1:0]  quat_w,
    input  logic signed [QUAT_WIDTH-1:0]  quat_i,
    input  logic signed [QUAT_WIDTH-1:0]  quat_j,
    input  logic signed [QUAT_WIDTH-1:0]  quat_k,
    input  logic signed [COORD_WIDTH-1:0] point_x,
    input  logic signed [COORD_WIDTH-1:0] point_y,
    input  logic signed [COORD_WIDTH-1:0] point_z,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [COORD_WIDTH-1:0] rot_x,
    output logic signed [COORD_WIDTH-1:0] rot_y,
    output logic signed [COORD_WIDTH-1:0] rot_z,
    output logic                          saturated
);
    import qvr_pkg::*;

    localparam int P1W  = QUAT_WIDTH + COORD_WIDTH;
    localparam int TW   = P1W + 2;
    localparam int P2W  = QUAT_WIDTH + TW;
    localparam int FULL = P2W + 2;
    localparam int FW   = (FULL > QVR_ACC_MAX_WIDTH) ? QVR_ACC_MAX_WIDTH : FULL;

    // per-stage valid bits and advance enables
    logic [4:0] vld_reg;
    logic [4:0] en;

    always_comb
    begin
        en[4] = !vld_reg[4] || !out_stall;
        en[3] = !vld_reg[3] || en[4];
        en[2] = !vld_reg[2] || en[3];
        en[1] = !vld_reg[1] || en[2];
        en[0] = !vld_reg[0] || en[1];
    end

    assign in_stall  = !en[0];
    assign out_valid = vld_reg[4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int s = 1; s < 5; s++)
            begin
                if (en[s])
                begin
                    vld_reg[s] <= vld_reg[s-1];
                end
            end
        end
    end

    // stage 1: every point coordinate times every quaternion component
    logic signed [QUAT_WIDTH-1:0]  qin [4];
    logic signed [COORD_WIDTH-1:0] pin [3];
    logic signed [P1W-1:0] pr_next [3][4];
    logic signed [P1W-1:0] pr_reg  [3][4];
    logic signed [QUAT_WIDTH-1:0] q1_reg [4];

    always_comb
    begin
        qin[0] = quat_w;
        qin[1] = quat_i;
        qin[2] = quat_j;
        qin[3] = quat_k;
        pin[0] = point_x;
        pin[1] = point_y;
        pin[2] = point_z;
        for (int c = 0; c < 3; c++)
        begin
            for (int q = 0; q < 4; q++)
            begin
                pr_next[c][q] = P1W'(pin[c]) * P1W'(qin[q]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            pr_reg <= pr_next;
            q1_reg <= qin;
        end
    end

    // stage 2: t = (0,p) * conj(q)
    logic signed [TW-1:0] t_next [4];
    logic signed [TW-1:0] t_reg  [4];
    logic signed [QUAT_WIDTH-1:0] q2_reg [4];

    always_comb
    begin
        t_next[0] = TW'(pr_reg[0][1]) + TW'(pr_reg[1][2]) + TW'(pr_reg[2][3]);
        t_next[1] = TW'(pr_reg[0][0]) - TW'(pr_reg[1][3]) + TW'(pr_reg[2][2]);
        t_next[2] = TW'(pr_reg[1][0]) - TW'(pr_reg[2][1]) + TW'(pr_reg[0][3]);
        t_next[3] = TW'(pr_reg[2][0]) - TW'(pr_reg[0][2]) + TW'(pr_reg[1][1]);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            t_reg  <= t_next;
            q2_reg <= q1_reg;
        end
    end

    // stage 3: every quaternion component times every component of t
    logic signed [P2W-1:0] fp_next [4][4];
    logic signed [P2W-1:0] fp_reg  [4][4];

    always_comb
    begin
        for (int a = 0; a < 4; a++)
        begin
            for (int b = 0; b < 4; b++)
            begin
                fp_next[a][b] = P2W'(q2_reg[a]) * P2W'(t_reg[b]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            fp_reg <= fp_next;
        end
    end

    // stage 4: vector part of f = q * t, kept to the accumulator width
    logic signed [FULL-1:0] fs [3];
    logic signed [FW-1:0]   f_next [3];
    logic signed [FW-1:0]   f_reg  [3];

    always_comb
    begin
        fs[0] = FULL'(fp_reg[2][3]) - FULL'(fp_reg[3][2])
              + FULL'(fp_reg[0][1]) + FULL'(fp_reg[1][0]);
        fs[1] = FULL'(fp_reg[3][1]) - FULL'(fp_reg[1][3])
              + FULL'(fp_reg[0][2]) + FULL'(fp_reg[2][0]);
        fs[2] = FULL'(fp_reg[1][2]) - FULL'(fp_reg[2][1])
              + FULL'(fp_reg[0][3]) + FULL'(fp_reg[3][0]);
        for (int n = 0; n < 3; n++)
        begin
            f_next[n] = signed'(fs[n][FW-1:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            f_reg <= f_next;
        end
    end

    // stage 5: round, rescale, saturate into the output register
    logic signed [COORD_WIDTH-1:0] rot_next [3];
    logic [2:0]                    clip;
    logic signed [COORD_WIDTH-1:0] rot_reg  [3];
    logic                          saturated_reg;

    for (genvar g = 0; g < 3; g++)
    begin : g_rs
        qvr_round_sat #(
            .QUAT_WIDTH  (QUAT_WIDTH),
            .COORD_WIDTH (COORD_WIDTH),
            .ACC_WIDTH   (FW)
        ) u_round_sat (
            .acc     (f_reg[g]),
            .coord   (rot_next[g]),
            .clipped (clip[g])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            rot_reg       <= rot_next;
            saturated_reg <= |clip;
        end
    end

    assign rot_x     = rot_reg[0];
    assign rot_y     = rot_reg[1];
    assign rot_z     = rot_reg[2];
    assign saturated = saturated_reg;

endmodule
